/* rtl/spq_pkg.sv */
// shared types and codes of the sorted priority scheduler queue
package spq_pkg;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LIST   = 2'd2;

	// status codes carried in m_tuser
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// one process entry
	typedef struct packed {
		logic [7:0]  priority_val;
		logic [15:0] burst_time;
		logic [7:0]  process_id;
	} entry_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   rem;
		logic   rot;
		entry_t ent;
	} cell_cmd_t;

endpackage

/* rtl/spq_cell.sv */
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module spq_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic [CW-1:0]      count,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_ge,
	input  spq_pkg::entry_t    right_entry,
	input  spq_pkg::entry_t    head_entry,
	input  logic               found_in,
	output spq_pkg::entry_t    entry,
	output logic               ge,
	output logic               found_out
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;
	logic            slot_valid;
	logic            slot_last;
	logic            match;

	// occupancy follows from the fill count
	assign slot_valid = CW'(INDEX) < count;
	assign slot_last  = count == CW'(INDEX + 1);
	assign ge         = slot_valid && (entry_q.priority_val >= cmd.ent.priority_val);
	assign match      = slot_valid && (entry_q.process_id == cmd.ent.process_id);
	assign found_out  = found_in | match;
	assign entry      = entry_q;

	// next entry: keep, take the new word, or shift from a neighbor
	always_comb begin
		entry_d = entry_q;
		if (cmd.ins) begin
			if (!ge) begin
				entry_d = left_ge ? cmd.ent : left_entry;
			end
		end else if (cmd.rem) begin
			if (found_out) begin
				entry_d = right_entry;
			end
		end else if (cmd.rot) begin
			if (slot_valid) begin
				entry_d = slot_last ? head_entry : right_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

/* rtl/sorted_priority_scheduler_queue.sv */
// top level: cell chain of sorted process entries with its stream control
//
//  channel  dir  fields (lowest bit first)                       accepted when
//  s_*      in   tuser: operation; tdata: id, burst, priority    s_tvalid & s_tready
//  m_*      out  tuser: status; tdata: id, burst, priority;      m_tvalid & m_tready
//                tlast: last_item
//
// an insert or remove updates the chain on the edge that accepts it: every cell decides
// its own move in parallel, and the remove search ripples a found flag down the chain.
// a list, once accepted, sends one word per entry out of cell 0, rotating the chain once
// per word; after count rotations the order is back as before.
// reset clears the fill count and control; slot contents are left as they are.
// input is held off while a list runs or while the output word is stalled.
module sorted_priority_scheduler_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // process_id[7:0], burst_time[23:8], priority_req[31:24]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // entry_process_id[7:0], entry_burst_time[23:8],
	                              // entry_priority[31:24]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rem_q;
	logic               m_valid_q;
	logic [1:0]         m_status_q;
	spq_pkg::entry_t    m_entry_q;
	logic               m_last_q;

	spq_pkg::cell_cmd_t cmd;
	spq_pkg::entry_t    ent   [DEPTH];
	logic               ge    [DEPTH];
	logic               found [DEPTH];

	logic               out_free;
	logic               acc;
	logic               full;
	logic               hit;
	logic               list_step;
	logic [1:0]         op;

	// handshake and decode
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign acc       = s_tvalid && s_tready;
	assign op        = s_tuser;
	assign full      = count_q == CW'(DEPTH);
	assign hit       = found[DEPTH-1];
	assign list_step = (state_q == S_LIST) && out_free;

	// command to the chain
	always_comb begin
		cmd.ent.process_id   = s_tdata[7:0];
		cmd.ent.burst_time   = s_tdata[23:8];
		cmd.ent.priority_val = s_tdata[31:24];
		cmd.ins              = acc && (op == spq_pkg::OP_INSERT) && !full;
		cmd.rem              = acc && (op == spq_pkg::OP_REMOVE);
		cmd.rot              = list_step;
	end

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t l_ent;
		spq_pkg::entry_t r_ent;
		logic            l_ge;
		logic            f_in;
		if (i == 0) begin : g_first
			assign l_ent = ent[i];
			assign l_ge  = 1'b1;
			assign f_in  = 1'b0;
		end else begin : g_mid
			assign l_ent = ent[i-1];
			assign l_ge  = ge[i-1];
			assign f_in  = found[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign r_ent = ent[i];
		end else begin : g_next
			assign r_ent = ent[i+1];
		end
		spq_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.count       (count_q),
			.left_entry  (l_ent),
			.left_ge     (l_ge),
			.right_entry (r_ent),
			.head_entry  (ent[0]),
			.found_in    (f_in),
			.entry       (ent[i]),
			.ge          (ge[i]),
			.found_out   (found[i])
		);
	end

	// control: state, fill count, list counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rem_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				case (op)
					spq_pkg::OP_INSERT: begin
						m_valid_q <= 1'b1;
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
					end
					spq_pkg::OP_REMOVE: begin
						m_valid_q <= 1'b1;
						if (hit) begin
							count_q <= count_q - CW'(1);
						end
					end
					spq_pkg::OP_LIST: begin
						if (count_q == '0) begin
							m_valid_q <= 1'b1;
						end else begin
							m_valid_q <= 1'b0;
							state_q   <= S_LIST;
							rem_q     <= count_q;
						end
					end
					default: begin
						m_valid_q <= 1'b0;
					end
				endcase
			end else if (list_step) begin
				m_valid_q <= 1'b1;
				rem_q     <= rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					state_q <= S_IDLE;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (acc) begin
			m_entry_q.process_id   <= s_tdata[7:0];
			m_entry_q.burst_time   <= '0;
			m_entry_q.priority_val <= '0;
			m_last_q               <= 1'b1;
			case (op)
				spq_pkg::OP_INSERT: m_status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
				spq_pkg::OP_REMOVE: m_status_q <= hit ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
				default:            m_status_q <= spq_pkg::ST_EMPTY;
			endcase
		end else if (list_step) begin
			m_entry_q  <= ent[0];
			m_status_q <= spq_pkg::ST_OK;
			m_last_q   <= rem_q == CW'(1);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {m_entry_q.priority_val, m_entry_q.burst_time, m_entry_q.process_id};
	assign m_tlast  = m_last_q;

	// fill count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond table size");

	// no input taken while a list is streaming
	a_list_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> !s_tready)
		else $error("input accepted during list");

	// last list word returns control to idle
	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		(list_step && rem_q == CW'(1)) |=> (state_q == S_IDLE) && m_tlast)
		else $error("list did not end on its last word");

	// a stalled output word leaves the table untouched
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready && state_q == S_IDLE) |=> $stable(count_q))
		else $error("table changed while output stalled");

endmodule
